FILE: rtl/nbody_gravity_euler_step_unit_defines.svh
// Assertion macros shared by the gravity step unit.
// Depends on nothing; included by files that check their own logic.
`ifndef NBODY_GRAVITY_EULER_STEP_UNIT_DEFINES_SVH
`define NBODY_GRAVITY_EULER_STEP_UNIT_DEFINES_SVH

// same-cycle implication under active-low reset
`define NBG_ASSERT_IMPLY(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under active-low reset
`define NBG_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/nbg_pkg.sv
// Shared types, constants and helpers of the gravity step unit.
// Depends on nothing; used by every module of the block.
package nbg_pkg;

    localparam int MAX_BODIES = 16;
    localparam int SLOT_W     = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int EMIT_CAP   = 16;
    localparam int CNT_W      = 5;
    localparam int LIMIT      = (MAX_BODIES < EMIT_CAP) ? MAX_BODIES : EMIT_CAP;
    localparam int CMP_W      = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

    localparam int MUL_W    = 128;
    localparam int MULB_W   = 34;
    localparam int MCNT_W   = 6;
    localparam int RAD_W    = 70;
    localparam int ROOT_W   = 35;
    localparam int SREM_W   = 38;
    localparam int R3_W     = 99;
    localparam int DREM_W   = 100;
    localparam int DCNT_W   = 8;
    localparam int SQ_STEPS = 35;
    localparam int DV_STEPS = 128;

    typedef enum logic [2:0] {
        CMD_LOAD    = 3'd0,
        CMD_STEP    = 3'd1,
        CMD_READ    = 3'd2,
        CMD_DESTROY = 3'd3,
        CMD_RESET   = 3'd4
    } cmd_t;

    localparam logic [1:0] CFG_GRAV  = 2'd0;
    localparam logic [1:0] CFG_DT    = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    typedef struct packed {
        logic [31:0]        mass;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] spos_x;
        logic signed [31:0] spos_y;
        logic signed [31:0] svel_x;
        logic signed [31:0] svel_y;
        logic               destroyed;
    } body_t;

    typedef struct packed {
        logic shift;
        logic write;
        logic restore;
    } ring_ctl_t;

    typedef struct packed {
        logic signed [31:0] self_px;
        logic signed [31:0] self_py;
        logic signed [31:0] other_px;
        logic signed [31:0] other_py;
        logic [31:0]        other_mass;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } force_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > 36'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -36'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: rtl/nbg_body_cell.sv
// One body slot of the rotating ring: holds a body and takes its neighbor's on shift.
// Depends on nbg_pkg.
module nbg_body_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  nbg_pkg::ring_ctl_t ctl,
    input  nbg_pkg::body_t    nbr,
    input  nbg_pkg::body_t    wr_body,
    output nbg_pkg::body_t    body
);

    nbg_pkg::body_t body_reg;
    nbg_pkg::body_t body_next;

    always_comb
    begin
        body_next = body_reg;
        if (ctl.restore)
        begin
            body_next.pos_x     = body_reg.spos_x;
            body_next.pos_y     = body_reg.spos_y;
            body_next.vel_x     = body_reg.svel_x;
            body_next.vel_y     = body_reg.svel_y;
            body_next.destroyed = 1'b0;
        end
        else if (ctl.write)
            body_next = wr_body;
        else if (ctl.shift)
            body_next = nbr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            body_reg <= '{destroyed: 1'b1, default: '0};
        else
            body_reg <= body_next;
    end

    assign body = body_reg;

endmodule

FILE: rtl/nbg_serial_mul.sv
// Shift-add multiplier, one bit of the narrow operand per cycle.
// Depends on nbg_pkg.
module nbg_serial_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nbg_pkg::MUL_W-1:0]   a,
    input  logic [nbg_pkg::MULB_W-1:0]  b,
    output logic                        done,
    output logic [nbg_pkg::MUL_W-1:0]   product
);

    logic [nbg_pkg::MUL_W-1:0]  acc_reg;
    logic [nbg_pkg::MUL_W-1:0]  a_reg;
    logic [nbg_pkg::MULB_W-1:0] b_reg;
    logic [nbg_pkg::MCNT_W-1:0] cnt_reg;
    logic                       done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == nbg_pkg::MCNT_W'(1));
            if (start)
                cnt_reg <= nbg_pkg::MCNT_W'(nbg_pkg::MULB_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - nbg_pkg::MCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= a;
            b_reg   <= b;
        end
        else if (cnt_reg != '0)
        begin
            if (b_reg[0])
                acc_reg <= acc_reg + a_reg;
            a_reg <= {a_reg[nbg_pkg::MUL_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[nbg_pkg::MULB_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: rtl/nbg_force_unit.sv
// Pull of one body on another: distance, bit-serial root, cube, two long divides.
// Depends on nbg_pkg and nbg_serial_mul.
module nbg_force_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  nbg_pkg::force_req_t req,
    input  logic [31:0]         grav,
    input  logic [15:0]         dt,
    output logic                done,
    output logic signed [31:0]  vel_x,
    output logic signed [31:0]  vel_y
);

    typedef enum logic [10:0] {
        F_IDLE = 11'b000_0000_0001,
        F_SQX  = 11'b000_0000_0010,
        F_SQY  = 11'b000_0000_0100,
        F_SQRT = 11'b000_0000_1000,
        F_RR   = 11'b000_0001_0000,
        F_RRR  = 11'b000_0010_0000,
        F_GM   = 11'b000_0100_0000,
        F_GMDT = 11'b000_1000_0000,
        F_NUM  = 11'b001_0000_0000,
        F_DIV  = 11'b010_0000_0000,
        F_DONE = 11'b100_0000_0000
    } fstate_t;

    fstate_t                        state_reg;
    logic                           mul_start_reg;
    logic [nbg_pkg::MUL_W-1:0]      mul_a_reg;
    logic [nbg_pkg::MULB_W-1:0]     mul_b_reg;
    logic                           mul_done;
    logic [nbg_pkg::MUL_W-1:0]      prod;
    logic [32:0]                    ux_reg, uy_reg;
    logic                           sx_reg, sy_reg;
    logic signed [31:0]             vx_reg, vy_reg;
    logic [65:0]                    r2_reg;
    logic [nbg_pkg::RAD_W-1:0]      rad_reg;
    logic [nbg_pkg::ROOT_W-1:0]     root_reg;
    logic [nbg_pkg::SREM_W-1:0]     srem_reg;
    logic [nbg_pkg::R3_W-1:0]       r3_reg;
    logic [79:0]                    gmdt_reg;
    logic [nbg_pkg::MUL_W-1:0]      num_reg;
    logic [nbg_pkg::MUL_W-1:0]      q_reg;
    logic [nbg_pkg::DREM_W-1:0]     drem_reg;
    logic [nbg_pkg::DCNT_W-1:0]     cnt_reg;
    logic                           axis_reg;

    logic signed [32:0]             dx, dy;
    logic [32:0]                    ux_c, uy_c;
    logic [nbg_pkg::SREM_W-1:0]     srem_sh, strial;
    logic                           sq_ge;
    logic [nbg_pkg::ROOT_W-1:0]     root_nx;
    logic [nbg_pkg::DREM_W-1:0]     drem_sh, dsub;
    logic                           d_ge;
    logic [nbg_pkg::MUL_W-1:0]      q_nx;
    logic [33:0]                    mag;
    logic signed [31:0]             vsel;
    logic signed [35:0]             dv, vsum;
    logic signed [31:0]             vnew;

    nbg_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .done    (mul_done),
        .product (prod)
    );

    always_comb
    begin
        dx      = {req.other_px[31], req.other_px} - {req.self_px[31], req.self_px};
        dy      = {req.other_py[31], req.other_py} - {req.self_py[31], req.self_py};
        ux_c    = dx[32] ? 33'(-dx) : 33'(dx);
        uy_c    = dy[32] ? 33'(-dy) : 33'(dy);
        srem_sh = {srem_reg[nbg_pkg::SREM_W-3:0], rad_reg[nbg_pkg::RAD_W-1 -: 2]};
        strial  = {1'b0, root_reg, 2'b01};
        sq_ge   = (srem_sh >= strial);
        root_nx = {root_reg[nbg_pkg::ROOT_W-2:0], sq_ge};
        drem_sh = {drem_reg[nbg_pkg::DREM_W-2:0], num_reg[nbg_pkg::MUL_W-1]};
        dsub    = {1'b0, r3_reg};
        d_ge    = (drem_sh >= dsub);
        q_nx    = {q_reg[nbg_pkg::MUL_W-2:0], d_ge};
        mag     = (q_nx > nbg_pkg::MUL_W'(34'h2_0000_0000)) ? 34'h2_0000_0000 : q_nx[33:0];
        vsel    = axis_reg ? vy_reg : vx_reg;
        dv      = (axis_reg ? sy_reg : sx_reg) ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
        vsum    = {{4{vsel[31]}}, vsel} + dv;
        vnew    = nbg_pkg::sat32(vsum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            mul_start_reg <= 1'b0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            case (state_reg)
                F_IDLE:
                    if (start)
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg     <= F_SQX;
                    end
                F_SQX:
                    if (mul_done)
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg     <= F_SQY;
                    end
                F_SQY:
                    if (mul_done)
                        state_reg <= F_SQRT;
                F_SQRT:
                    if (cnt_reg == nbg_pkg::DCNT_W'(1))
                    begin
                        if (root_nx == '0)
                            state_reg <= F_DONE;
                        else
                        begin
                            mul_start_reg <= 1'b1;
                            state_reg     <= F_RR;
                        end
                    end
                F_RR:
                    if (mul_done)
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg     <= F_RRR;
                    end
                F_RRR:
                    if (mul_done)
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg     <= F_GM;
                    end
                F_GM:
                    if (mul_done)
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg     <= F_GMDT;
                    end
                F_GMDT:
                    if (mul_done)
                    begin
                        mul_start_reg <= 1'b1;
                        state_reg     <= F_NUM;
                    end
                F_NUM:
                    if (mul_done)
                        state_reg <= F_DIV;
                F_DIV:
                    if (cnt_reg == nbg_pkg::DCNT_W'(1))
                    begin
                        if (!axis_reg)
                        begin
                            mul_start_reg <= 1'b1;
                            state_reg     <= F_NUM;
                        end
                        else
                            state_reg <= F_DONE;
                    end
                F_DONE:
                    state_reg <= F_IDLE;
                default:
                    state_reg <= F_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
                if (start)
                begin
                    ux_reg    <= ux_c;
                    uy_reg    <= uy_c;
                    sx_reg    <= dx[32];
                    sy_reg    <= dy[32];
                    vx_reg    <= req.vel_x;
                    vy_reg    <= req.vel_y;
                    mul_a_reg <= nbg_pkg::MUL_W'(ux_c);
                    mul_b_reg <= nbg_pkg::MULB_W'(ux_c);
                end
            F_SQX:
                if (mul_done)
                begin
                    r2_reg    <= prod[65:0];
                    mul_a_reg <= nbg_pkg::MUL_W'(uy_reg);
                    mul_b_reg <= nbg_pkg::MULB_W'(uy_reg);
                end
            F_SQY:
                if (mul_done)
                begin
                    rad_reg  <= {4'b0000, r2_reg + prod[65:0]};
                    root_reg <= '0;
                    srem_reg <= '0;
                    cnt_reg  <= nbg_pkg::DCNT_W'(nbg_pkg::SQ_STEPS);
                end
            F_SQRT:
            begin
                srem_reg  <= sq_ge ? (srem_sh - strial) : srem_sh;
                root_reg  <= root_nx;
                rad_reg   <= {rad_reg[nbg_pkg::RAD_W-3:0], 2'b00};
                cnt_reg   <= cnt_reg - nbg_pkg::DCNT_W'(1);
                mul_a_reg <= nbg_pkg::MUL_W'(root_nx);
                mul_b_reg <= root_nx[nbg_pkg::MULB_W-1:0];
            end
            F_RR:
                if (mul_done)
                begin
                    mul_a_reg <= prod;
                    mul_b_reg <= root_reg[nbg_pkg::MULB_W-1:0];
                end
            F_RRR:
                if (mul_done)
                begin
                    r3_reg    <= prod[nbg_pkg::R3_W-1:0];
                    mul_a_reg <= nbg_pkg::MUL_W'(grav);
                    mul_b_reg <= nbg_pkg::MULB_W'(req.other_mass);
                end
            F_GM:
                if (mul_done)
                begin
                    mul_a_reg <= prod;
                    mul_b_reg <= nbg_pkg::MULB_W'(dt);
                end
            F_GMDT:
                if (mul_done)
                begin
                    gmdt_reg  <= prod[79:0];
                    mul_a_reg <= prod;
                    mul_b_reg <= nbg_pkg::MULB_W'(ux_reg);
                    axis_reg  <= 1'b0;
                end
            F_NUM:
                if (mul_done)
                begin
                    num_reg  <= prod;
                    drem_reg <= '0;
                    q_reg    <= '0;
                    cnt_reg  <= nbg_pkg::DCNT_W'(nbg_pkg::DV_STEPS);
                end
            F_DIV:
            begin
                drem_reg <= d_ge ? (drem_sh - dsub) : drem_sh;
                num_reg  <= {num_reg[nbg_pkg::MUL_W-2:0], 1'b0};
                q_reg    <= q_nx;
                cnt_reg  <= cnt_reg - nbg_pkg::DCNT_W'(1);
                if (cnt_reg == nbg_pkg::DCNT_W'(1))
                begin
                    if (!axis_reg)
                    begin
                        vx_reg    <= vnew;
                        axis_reg  <= 1'b1;
                        mul_a_reg <= nbg_pkg::MUL_W'(gmdt_reg);
                        mul_b_reg <= nbg_pkg::MULB_W'(uy_reg);
                    end
                    else
                        vy_reg <= vnew;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done  = (state_reg == F_DONE);
    assign vel_x = vx_reg;
    assign vel_y = vy_reg;

endmodule

FILE: rtl/nbody_gravity_euler_step_unit.sv
// Direct-sum 2D gravity unit with explicit Euler steps over a ring of body cells.
// The ring rotates one slot per cycle to bring a body to its head; one shared force
// unit works each live ordered pair. Load, destroy and read rotate the ring until
// the addressed slot reaches its head; reset-all restores every cell at once. A step
// runs, for each live ordered pair, one bit-serial root, eight shift-add multiplies
// and two long divides, plus ring rotation to each slot in use. Requests are taken
// one at a time; a finished result waits in the output register.
// Depends on nbg_pkg, nbg_body_cell, nbg_force_unit and the defines header.
`include "nbody_gravity_euler_step_unit_defines.svh"

module nbody_gravity_euler_step_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [2:0]         command,
    input  logic [3:0]         body_index,
    input  logic [31:0]        body_mass,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    output logic               res_valid,
    input  logic               res_stall,
    output logic [3:0]         out_index,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic signed [31:0] out_vel_x,
    output logic signed [31:0] out_vel_y,
    output logic               out_destroyed,
    output logic               last
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b0_0000_0001,
        S_EDIT    = 9'b0_0000_0010,
        S_V_SELF  = 9'b0_0000_0100,
        S_V_OTHER = 9'b0_0000_1000,
        S_V_WAIT  = 9'b0_0001_0000,
        S_V_WB    = 9'b0_0010_0000,
        S_P_SEEK  = 9'b0_0100_0000,
        S_P_WR    = 9'b0_1000_0000,
        S_EMIT    = 9'b1_0000_0000
    } state_t;

    localparam int CW = nbg_pkg::CNT_W;
    localparam int SW = nbg_pkg::SLOT_W;
    localparam int XW = nbg_pkg::CMP_W;

    state_t                 state_reg, state_next;
    logic [SW-1:0]          rot_reg, rot_next;
    logic [CW-1:0]          i_reg, i_next, j_reg, j_next, n_reg, n_next;
    logic [31:0]            grav_reg;
    logic [15:0]            dt_reg;
    logic [4:0]             count_reg;
    nbg_pkg::cmd_t          op_reg, op_next;
    logic [31:0]            ld_mass_reg, ld_mass_next;
    logic signed [31:0]     ld_px_reg, ld_py_reg, ld_vx_reg, ld_vy_reg;
    logic signed [31:0]     ld_px_next, ld_py_next, ld_vx_next, ld_vy_next;
    logic signed [31:0]     self_px_reg, self_py_reg, self_px_next, self_py_next;
    logic signed [31:0]     vx_reg, vy_reg, vx_next, vy_next;
    logic [47:0]            px_prod_reg, py_prod_reg, px_prod_next, py_prod_next;
    logic                   negx_reg, negy_reg, negx_next, negy_next;
    logic                   res_valid_reg;
    logic [3:0]             o_index_reg;
    logic signed [31:0]     o_px_reg, o_py_reg, o_vx_reg, o_vy_reg;
    logic                   o_destroyed_reg, o_last_reg;

    nbg_pkg::ring_ctl_t     ctl;
    nbg_pkg::body_t         cells [nbg_pkg::MAX_BODIES];
    nbg_pkg::body_t         head, wr_body;
    nbg_pkg::force_req_t    freq;
    logic                   force_start, force_done;
    logic signed [31:0]     force_vx, force_vy;
    logic                   at_i, at_j, i_end, j_end, out_free, out_load, out_last;
    logic [CW-1:0]          i_inc, j_inc, n_clamp;
    logic [31:0]            mvx, mvy;
    logic signed [35:0]     dpx, dpy;
    logic                   accept;

    genvar k;
    generate
        for (k = 0; k < nbg_pkg::MAX_BODIES; k++)
        begin : g_ring
            localparam int NB = (k + 1) % nbg_pkg::MAX_BODIES;
            nbg_pkg::ring_ctl_t cctl;
            assign cctl.shift   = ctl.shift;
            assign cctl.write   = ctl.write && (k == 0);
            assign cctl.restore = ctl.restore;
            nbg_body_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (cctl),
                .nbr     (cells[NB]),
                .wr_body (wr_body),
                .body    (cells[k])
            );
        end
    endgenerate

    assign head = cells[0];

    assign freq.self_px    = self_px_reg;
    assign freq.self_py    = self_py_reg;
    assign freq.other_px   = head.pos_x;
    assign freq.other_py   = head.pos_y;
    assign freq.other_mass = head.mass;
    assign freq.vel_x      = vx_reg;
    assign freq.vel_y      = vy_reg;

    nbg_force_unit u_force (
        .clk   (clk),
        .rst_n (rst_n),
        .start (force_start),
        .req   (freq),
        .grav  (grav_reg),
        .dt    (dt_reg),
        .done  (force_done),
        .vel_x (force_vx),
        .vel_y (force_vy)
    );

    always_comb
    begin
        accept   = req_valid && !req_stall;
        at_i     = (XW'(rot_reg) == XW'(i_reg));
        at_j     = (XW'(rot_reg) == XW'(j_reg));
        i_inc    = i_reg + CW'(1);
        j_inc    = j_reg + CW'(1);
        i_end    = (i_inc == n_reg);
        j_end    = (j_inc == n_reg);
        out_free = !res_valid_reg || !res_stall;
        if (count_reg == '0)
            n_clamp = CW'(1);
        else if (int'(count_reg) > nbg_pkg::LIMIT)
            n_clamp = CW'(nbg_pkg::LIMIT);
        else
            n_clamp = CW'(count_reg);
        mvx = head.vel_x[31] ? (~head.vel_x + 32'd1) : head.vel_x;
        mvy = head.vel_y[31] ? (~head.vel_y + 32'd1) : head.vel_y;
        dpx = negx_reg ? -$signed({4'b0000, px_prod_reg[47:16]})
                       : $signed({4'b0000, px_prod_reg[47:16]});
        dpy = negy_reg ? -$signed({4'b0000, py_prod_reg[47:16]})
                       : $signed({4'b0000, py_prod_reg[47:16]});

        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        n_next       = n_reg;
        op_next      = op_reg;
        ld_mass_next = ld_mass_reg;
        ld_px_next   = ld_px_reg;
        ld_py_next   = ld_py_reg;
        ld_vx_next   = ld_vx_reg;
        ld_vy_next   = ld_vy_reg;
        self_px_next = self_px_reg;
        self_py_next = self_py_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        px_prod_next = px_prod_reg;
        py_prod_next = py_prod_reg;
        negx_next    = negx_reg;
        negy_next    = negy_reg;
        ctl          = '0;
        wr_body      = head;
        force_start  = 1'b0;
        out_load     = 1'b0;
        out_last     = 1'b0;

        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    op_next      = nbg_pkg::cmd_t'(command);
                    ld_mass_next = body_mass;
                    ld_px_next   = pos_x;
                    ld_py_next   = pos_y;
                    ld_vx_next   = vel_x;
                    ld_vy_next   = vel_y;
                    case (command)
                        nbg_pkg::CMD_LOAD, nbg_pkg::CMD_DESTROY:
                            if (int'(body_index) < nbg_pkg::MAX_BODIES)
                            begin
                                i_next     = CW'(body_index);
                                state_next = S_EDIT;
                            end
                        nbg_pkg::CMD_STEP:
                        begin
                            n_next     = n_clamp;
                            i_next     = '0;
                            state_next = S_V_SELF;
                        end
                        nbg_pkg::CMD_READ:
                            if (int'(body_index) < nbg_pkg::MAX_BODIES)
                            begin
                                i_next     = CW'(body_index);
                                n_next     = CW'(body_index) + CW'(1);
                                state_next = S_EMIT;
                            end
                        nbg_pkg::CMD_RESET:
                            ctl.restore = 1'b1;
                        default:
                        begin
                        end
                    endcase
                end
            S_EDIT:
                if (at_i)
                begin
                    ctl.write = 1'b1;
                    if (op_reg == nbg_pkg::CMD_LOAD)
                    begin
                        wr_body.mass      = ld_mass_reg;
                        wr_body.pos_x     = ld_px_reg;
                        wr_body.pos_y     = ld_py_reg;
                        wr_body.vel_x     = ld_vx_reg;
                        wr_body.vel_y     = ld_vy_reg;
                        wr_body.spos_x    = ld_px_reg;
                        wr_body.spos_y    = ld_py_reg;
                        wr_body.svel_x    = ld_vx_reg;
                        wr_body.svel_y    = ld_vy_reg;
                        wr_body.destroyed = 1'b0;
                    end
                    else
                        wr_body.destroyed = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    ctl.shift = 1'b1;
            S_V_SELF:
                if (at_i)
                begin
                    if (head.destroyed)
                    begin
                        i_next = i_inc;
                        if (i_end)
                        begin
                            i_next     = '0;
                            state_next = S_P_SEEK;
                        end
                    end
                    else
                    begin
                        self_px_next = head.pos_x;
                        self_py_next = head.pos_y;
                        vx_next      = head.vel_x;
                        vy_next      = head.vel_y;
                        j_next       = '0;
                        state_next   = S_V_OTHER;
                    end
                end
                else
                    ctl.shift = 1'b1;
            S_V_OTHER:
                if (at_j)
                begin
                    if ((j_reg != i_reg) && !head.destroyed)
                    begin
                        force_start = 1'b1;
                        state_next  = S_V_WAIT;
                    end
                    else
                    begin
                        j_next = j_inc;
                        if (j_end)
                            state_next = S_V_WB;
                    end
                end
                else
                    ctl.shift = 1'b1;
            S_V_WAIT:
                if (force_done)
                begin
                    vx_next    = force_vx;
                    vy_next    = force_vy;
                    j_next     = j_inc;
                    state_next = j_end ? S_V_WB : S_V_OTHER;
                end
            S_V_WB:
                if (at_i)
                begin
                    ctl.write     = 1'b1;
                    wr_body.vel_x = vx_reg;
                    wr_body.vel_y = vy_reg;
                    i_next        = i_inc;
                    state_next    = S_V_SELF;
                    if (i_end)
                    begin
                        i_next     = '0;
                        state_next = S_P_SEEK;
                    end
                end
                else
                    ctl.shift = 1'b1;
            S_P_SEEK:
                if (at_i)
                begin
                    if (head.destroyed)
                    begin
                        i_next = i_inc;
                        if (i_end)
                        begin
                            i_next     = '0;
                            state_next = S_EMIT;
                        end
                    end
                    else
                    begin
                        px_prod_next = {16'h0000, mvx} * {32'h0000_0000, dt_reg};
                        py_prod_next = {16'h0000, mvy} * {32'h0000_0000, dt_reg};
                        negx_next    = head.vel_x[31];
                        negy_next    = head.vel_y[31];
                        state_next   = S_P_WR;
                    end
                end
                else
                    ctl.shift = 1'b1;
            S_P_WR:
            begin
                ctl.write     = 1'b1;
                wr_body.pos_x = nbg_pkg::sat32({{4{head.pos_x[31]}}, head.pos_x} + dpx);
                wr_body.pos_y = nbg_pkg::sat32({{4{head.pos_y[31]}}, head.pos_y} + dpy);
                i_next        = i_inc;
                state_next    = S_P_SEEK;
                if (i_end)
                begin
                    i_next     = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
                if (at_i)
                begin
                    if (out_free)
                    begin
                        out_load = 1'b1;
                        out_last = i_end;
                        i_next   = i_inc;
                        if (i_end)
                            state_next = S_IDLE;
                    end
                end
                else
                    ctl.shift = 1'b1;
            default:
                state_next = S_IDLE;
        endcase

        if (ctl.shift)
            rot_next = (int'(rot_reg) == nbg_pkg::MAX_BODIES - 1) ? '0 : rot_reg + SW'(1);
        else
            rot_next = rot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rot_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= CW'(1);
            grav_reg      <= 32'd65536;
            dt_reg        <= 16'd1092;
            count_reg     <= 5'd16;
            res_valid_reg <= 1'b0;
            op_reg        <= nbg_pkg::CMD_LOAD;
        end
        else
        begin
            state_reg <= state_next;
            rot_reg   <= rot_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            op_reg    <= op_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    nbg_pkg::CFG_GRAV:  grav_reg  <= cfg_data;
                    nbg_pkg::CFG_DT:    dt_reg    <= cfg_data[15:0];
                    nbg_pkg::CFG_COUNT: count_reg <= cfg_data[4:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ld_mass_reg <= ld_mass_next;
        ld_px_reg   <= ld_px_next;
        ld_py_reg   <= ld_py_next;
        ld_vx_reg   <= ld_vx_next;
        ld_vy_reg   <= ld_vy_next;
        self_px_reg <= self_px_next;
        self_py_reg <= self_py_next;
        vx_reg      <= vx_next;
        vy_reg      <= vy_next;
        px_prod_reg <= px_prod_next;
        py_prod_reg <= py_prod_next;
        negx_reg    <= negx_next;
        negy_reg    <= negy_next;
        if (out_load)
        begin
            o_index_reg     <= i_reg[3:0];
            o_px_reg        <= head.pos_x;
            o_py_reg        <= head.pos_y;
            o_vx_reg        <= head.vel_x;
            o_vy_reg        <= head.vel_y;
            o_destroyed_reg <= head.destroyed;
            o_last_reg      <= out_last;
        end
    end

    assign cfg_ready     = 1'b1;
    assign req_stall     = (state_reg != S_IDLE);
    assign res_valid     = res_valid_reg;
    assign out_index     = o_index_reg;
    assign out_pos_x     = o_px_reg;
    assign out_pos_y     = o_py_reg;
    assign out_vel_x     = o_vx_reg;
    assign out_vel_y     = o_vy_reg;
    assign out_destroyed = o_destroyed_reg;
    assign last          = o_last_reg;

    `NBG_ASSERT_IMPLY(a_pull_live_other, clk, rst_n, force_start, !head.destroyed && !at_i, "pull started on a destroyed body or on itself")
    `NBG_ASSERT_IMPLY(a_ring_hold, clk, rst_n, ctl.write || ctl.restore, !ctl.shift, "ring shifted while its head was written")
    `NBG_ASSERT_NEXT(a_last_idle, clk, rst_n, out_load && out_last, state_reg == S_IDLE, "block busy after the final result")

endmodule
